// ===== src/assert_macros.svh =====
// Assertion macros shared by the color ramp RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock edge, off while in reset.
`define CRI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant check, sampled on the rising clock edge, off while in reset.
`define CRI_ASSERT_INV(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== src/cri_pkg.sv =====
// Shared types and constants for the color ramp interpolator.
// No dependencies; imported by every module of the block.
package cri_pkg;

  localparam int STOP_REGS     = 8;
  localparam int STOP_W        = 49;
  localparam int VALID_BIT     = 48;
  localparam int KEY_W         = 16;
  localparam int COLOR_W       = 32;
  localparam int CH_W          = 8;
  localparam int STOP_IDX_W    = 3;
  localparam int STOP_CNT_W    = 4;
  localparam int CFG_IDX_W     = 4;
  localparam int DEF_NUM_STOPS = 8;
  localparam int DEF_FRAC_BITS = 8;

  localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

  // One classified item: blend color ca toward cb by num/den.
  typedef struct packed {
    logic [KEY_W-1:0]   num;
    logic [KEY_W-1:0]   den;
    logic [COLOR_W-1:0] ca;
    logic [COLOR_W-1:0] cb;
  } cri_item_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } cri_q_stat_t;

endpackage

// ===== src/color_ramp_interpolator_top.sv =====
// Top level of the color ramp interpolator: front classifier, queue, back end.
// Depends on cri_pkg, cri_front, cri_queue and cri_back.
//
// Maps each 16-bit sample to an RGBA color through up to NUM_STOPS color
// stops written on the cfg port (index i = stop i; bit 48 valid, bits 47:32
// key, bits 31:0 RGBA). The block accepts one item per cycle while in_stall is
// low and delivers one result per item, in order. The classify register loads
// at the edge that accepts the item; the item is then written to the queue,
// passes FRACTION_BITS + 1 divider stages (one quotient bit per stage) and
// lands in the blend/output register, which raises out_valid. A two-entry
// queue decouples the classifier from the divider pipeline; in_stall rises only
// when out_stall has held the back end long enough to fill it. The user must
// write stops only while no item is in flight; the block does not enforce it.
module color_ramp_interpolator_top #(
  parameter int NUM_STOPS     = cri_pkg::DEF_NUM_STOPS,
  parameter int FRACTION_BITS = cri_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cri_pkg::STOP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cri_pkg::KEY_W-1:0]     in_sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cri_pkg::CH_W-1:0]      out_red,
  output logic [cri_pkg::CH_W-1:0]      out_green,
  output logic [cri_pkg::CH_W-1:0]      out_blue,
  output logic [cri_pkg::CH_W-1:0]      out_alpha
);
  import cri_pkg::*;

  cri_q_stat_t q_stat;
  cri_item_t   push_item;
  cri_item_t   pop_item;
  logic        push;
  logic        pop;

  // Classifies each sample into a segment and forms the divide operands.
  cri_front #(.NUM_STOPS(NUM_STOPS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_sample_value,
    .q_stat, .push, .push_item
  );

  // Lets the two halves stall independently.
  cri_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .pop_item, .q_stat
  );

  // Computes the fraction and the blended color.
  cri_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .q_stat, .pop_item, .pop,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_alpha
  );

endmodule

// ===== src/cri_front.sv =====
// Front end: color stop registers and per-sample segment classification.
// Depends on cri_pkg.
module cri_front #(
  parameter int NUM_STOPS = cri_pkg::DEF_NUM_STOPS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cri_pkg::STOP_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cri_pkg::KEY_W-1:0]    in_sample_value,
  input  cri_pkg::cri_q_stat_t         q_stat,
  output logic                         push,
  output cri_pkg::cri_item_t           push_item
);
  import cri_pkg::*;

  logic [STOP_W-1:0] stop_r [STOP_REGS];
  logic              f_valid_r, f_valid_nxt;
  cri_item_t         f_item_r, f_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STOP_REGS; i++) stop_r[i] <= '0;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(STOP_REGS)) begin
      stop_r[cfg_index[STOP_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    logic [STOP_CNT_W-1:0] cnt;
    logic [STOP_CNT_W-1:0] cnt_m1;
    logic                  run;
    logic                  found;
    logic [STOP_IDX_W-1:0] hit;
    logic [STOP_IDX_W-1:0] idx_a;
    logic [STOP_IDX_W-1:0] idx_b;
    logic                  blend;
    logic [KEY_W-1:0]      key_a;
    logic [KEY_W-1:0]      key_b;
    logic [COLOR_W-1:0]    col_a;
    logic [COLOR_W-1:0]    col_b;
    cnt   = '0;
    run   = 1'b1;
    found = 1'b0;
    hit   = '0;
    key_a = '0;
    key_b = '0;
    col_a = '0;
    col_b = '0;
    for (int i = 0; i < NUM_STOPS; i++) begin
      run = run & stop_r[i][VALID_BIT];
      if (run) cnt = cnt + 1'b1;
    end
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (!found && STOP_CNT_W'(i) < cnt &&
          stop_r[i][VALID_BIT-1 -: KEY_W] >= in_sample_value) begin
        found = 1'b1;
        hit   = STOP_IDX_W'(i);
      end
    end
    cnt_m1 = cnt - 1'b1;
    blend  = found && (hit != '0);
    idx_a  = hit - 1'b1;
    idx_b  = found ? hit : cnt_m1[STOP_IDX_W-1:0];
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (STOP_IDX_W'(i) == idx_a) begin
        key_a = stop_r[i][VALID_BIT-1 -: KEY_W];
        col_a = stop_r[i][COLOR_W-1:0];
      end
      if (STOP_IDX_W'(i) == idx_b) begin
        key_b = stop_r[i][VALID_BIT-1 -: KEY_W];
        col_b = stop_r[i][COLOR_W-1:0];
      end
    end
    // A flat color runs through the blender as num == den, giving exactly cb.
    if (cnt == '0) begin
      f_item_nxt = '{num: KEY_W'(1), den: KEY_W'(1), ca: OPAQUE_BLACK, cb: OPAQUE_BLACK};
    end else if (!blend) begin
      f_item_nxt = '{num: KEY_W'(1), den: KEY_W'(1), ca: col_b, cb: col_b};
    end else begin
      f_item_nxt = '{num: in_sample_value - key_a, den: key_b - key_a, ca: col_a, cb: col_b};
    end
  end

  assign push        = f_valid_r && !q_stat.full;
  assign in_stall    = f_valid_r && q_stat.full;
  assign f_valid_nxt = in_stall ? f_valid_r : in_valid;
  assign push_item   = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ===== src/cri_queue.sv =====
// Two-entry queue between the classifier and the blend pipeline.
// Depends on cri_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cri_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cri_pkg::cri_item_t   push_item,
  input  logic                 pop,
  output cri_pkg::cri_item_t   pop_item,
  output cri_pkg::cri_q_stat_t q_stat
);
  import cri_pkg::*;

  cri_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_stat.full      = (count_r == 2'd2);
  assign q_stat.not_empty = (count_r != 2'd0);
  assign pop_item         = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
  assign count_nxt  = count_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `CRI_ASSERT_INV(a_count_range, clk, rst_n, count_r != 2'd3, "queue count out of range")
  `CRI_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, count_r != 2'd0, "pop from empty queue")
  `CRI_ASSERT_IMP(a_push_grows, clk, rst_n, push && !pop, ##1 count_r == $past(count_r) + 2'd1,
    "push without pop did not grow queue")

endmodule

// ===== src/cri_back.sv =====
// Back end: pipelined restoring divider for the blend fraction, then the
// four-channel linear blend and the output register. Depends on cri_pkg.
module cri_back #(
  parameter int FRACTION_BITS = cri_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cri_pkg::cri_q_stat_t         q_stat,
  input  cri_pkg::cri_item_t           pop_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cri_pkg::CH_W-1:0]     out_red,
  output logic [cri_pkg::CH_W-1:0]     out_green,
  output logic [cri_pkg::CH_W-1:0]     out_blue,
  output logic [cri_pkg::CH_W-1:0]     out_alpha
);
  import cri_pkg::*;

  localparam int STAGES = FRACTION_BITS + 1;
  localparam int Q_W    = FRACTION_BITS + 1;
  localparam int P_W    = CH_W + FRACTION_BITS + 2;
  localparam logic [Q_W-1:0] ONE  = Q_W'(1) << FRACTION_BITS;
  localparam logic [P_W-1:0] HALF = P_W'(1) << (FRACTION_BITS - 1);

  logic               v_r   [STAGES];
  logic [KEY_W-1:0]   rem_r [STAGES];
  logic [KEY_W-1:0]   den_r [STAGES];
  logic [Q_W-1:0]     q_r   [STAGES];
  logic [COLOR_W-1:0] ca_r  [STAGES];
  logic [COLOR_W-1:0] cb_r  [STAGES];
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_col_r, out_col_nxt;
  logic               adv;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && q_stat.not_empty;

  // Stage 0 takes the top quotient bit; each later stage one more bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) v_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_stat.not_empty;
      for (int s = 1; s < STAGES; s++) v_r[s] <= v_r[s-1];
      out_valid_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [KEY_W:0] sh;
    logic           bit_q;
    if (adv) begin
      bit_q     = pop_item.num >= pop_item.den;
      rem_r[0] <= bit_q ? pop_item.num - pop_item.den : pop_item.num;
      q_r[0]   <= {bit_q, {FRACTION_BITS{1'b0}}};
      den_r[0] <= pop_item.den;
      ca_r[0]  <= pop_item.ca;
      cb_r[0]  <= pop_item.cb;
      for (int s = 1; s < STAGES; s++) begin
        sh    = {rem_r[s-1], 1'b0};
        bit_q = sh >= {1'b0, den_r[s-1]};
        rem_r[s] <= bit_q ? KEY_W'(sh - {1'b0, den_r[s-1]}) : sh[KEY_W-1:0];
        q_r[s]   <= q_r[s-1] | (Q_W'(bit_q) << (FRACTION_BITS - s));
        den_r[s] <= den_r[s-1];
        ca_r[s]  <= ca_r[s-1];
        cb_r[s]  <= cb_r[s-1];
      end
      out_col_r <= out_col_nxt;
    end
  end

  always_comb begin
    logic [Q_W-1:0] d;
    logic [P_W-1:0] acc;
    d = q_r[STAGES-1];
    out_col_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      acc = P_W'(ca_r[STAGES-1][c*CH_W +: CH_W]) * P_W'(ONE - d)
          + P_W'(cb_r[STAGES-1][c*CH_W +: CH_W]) * P_W'(d) + HALF;
      out_col_nxt[c*CH_W +: CH_W] = acc[FRACTION_BITS +: CH_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_col_r[31:24];
  assign out_green = out_col_r[23:16];
  assign out_blue  = out_col_r[15:8];
  assign out_alpha = out_col_r[7:0];

endmodule
